[hdl/assert_macros.svh]
// Assertion helpers used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent at one edge implies the consequent at the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ft12_pkg.sv]
package ft12_pkg;

    localparam logic [7:0] FIXED_START = 8'h10;
    localparam logic [7:0] VAR_START   = 8'h68;
    localparam logic [7:0] END_CHAR    = 8'h16;

    // Configuration register indexes.
    localparam logic CFG_LINK_ADDR_BYTES = 1'b0;
    localparam logic CFG_OWN_LINK_ADDR   = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_START  = 3'd1,
        ST_LEN_BAD    = 3'd2,
        ST_START2_BAD = 3'd3,
        ST_END_BAD    = 3'd4,
        ST_ADDR_BAD   = 3'd5,
        ST_SUM_BAD    = 3'd6
    } status_t;

    typedef struct packed {
        status_t    status;
        logic       is_variable;
        logic [7:0] control_field;
        logic [7:0] user_length;
    } result_t;

endpackage

[hdl/ft12_frame_checker_core.sv]
// A received byte waits in the input register until the result register can take it,
// and a frame's result word stays in the result register until the sink takes it.
// Throughput: one received byte per cycle unless the sink stalls; per byte the parser does
// one 8-bit add and a few compares between the input register and the result register.
// Reset (rst_n, asynchronous, active low): hunting for a start byte, both
// registers empty, one-byte link address, own link address 0.
module ft12_frame_checker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] status, [10:3] control_field, [18:11] user_length
    output logic        m_tuser,   // [0] is_variable
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);
    import ft12_pkg::*;

    logic        advance;
    logic        byte_valid;
    logic [7:0]  byte_data;
    logic        res_valid;
    result_t     res;
    logic [1:0]  link_address_bytes_reg;
    logic [15:0] own_link_address_reg;

    // A word leaves the input register whenever the result register can take it.
    assign advance = byte_valid && (!m_tvalid || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_address_bytes_reg <= 2'd1;
            own_link_address_reg   <= 16'h0000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINK_ADDR_BYTES: link_address_bytes_reg <= cfg_wdata[1:0];
                CFG_OWN_LINK_ADDR:   own_link_address_reg   <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    ft12_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    ft12_parser u_parser (
        .clk                (clk),
        .rst_n              (rst_n),
        .advance            (advance),
        .rx_byte            (byte_data),
        .link_address_bytes (link_address_bytes_reg),
        .own_link_address   (own_link_address_reg),
        .res_valid          (res_valid),
        .res                (res)
    );

    ft12_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );
endmodule

[hdl/ft12_in_reg.sv]
module ft12_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // The register frees up in the same cycle that its word moves on.
    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;
endmodule

[hdl/ft12_parser.sv]
module ft12_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       rx_byte,
    input  logic [1:0]       link_address_bytes,
    input  logic [15:0]      own_link_address,
    output logic             res_valid,
    output ft12_pkg::result_t res
);
    import ft12_pkg::*;

    logic [8:0] pos_reg,      pos_next;
    logic       var_reg,      var_next;
    logic [7:0] len_reg,      len_next;
    logic [7:0] sum_reg,      sum_next;
    logic [7:0] addr_lo_reg,  addr_lo_next;
    logic [7:0] addr_hi_reg,  addr_hi_next;
    logic [7:0] ctrl_reg,     ctrl_next;
    logic       sum_bad_reg,  sum_bad_next;

    logic       two_byte_addr;
    logic       addr_ok;
    logic [8:0] fixed_end_pos;
    logic [8:0] data_last_pos;
    logic [8:0] pos_inc;

    assign two_byte_addr = (link_address_bytes == 2'd2);
    assign addr_ok = ({two_byte_addr ? addr_hi_reg : 8'h00, addr_lo_reg} == own_link_address);
    assign fixed_end_pos = two_byte_addr ? 9'd5 : 9'd4;
    assign data_last_pos = {1'b0, len_reg} + 9'd3;
    assign pos_inc = pos_reg + 9'd1;

    always_comb
    begin
        pos_next     = pos_reg;
        var_next     = var_reg;
        len_next     = len_reg;
        sum_next     = sum_reg;
        addr_lo_next = addr_lo_reg;
        addr_hi_next = addr_hi_reg;
        ctrl_next    = ctrl_reg;
        sum_bad_next = sum_bad_reg;
        res_valid    = 1'b0;
        res          = '{status: ST_OK, is_variable: 1'b0,
                         control_field: 8'h00, user_length: 8'h00};

        if (pos_reg == 9'd0)
        begin
            if (rx_byte != FIXED_START && rx_byte != VAR_START)
            begin
                res_valid  = 1'b1;
                res.status = ST_NOT_START;
            end
            else
            begin
                var_next     = (rx_byte == VAR_START);
                len_next     = 8'h00;
                sum_next     = 8'h00;
                addr_lo_next = 8'h00;
                addr_hi_next = 8'h00;
                ctrl_next    = 8'h00;
                sum_bad_next = 1'b0;
                pos_next     = 9'd1;
            end
        end
        else if (!var_reg)
        begin
            // A shortened address setting can leave the position past the end.
            if (pos_reg >= fixed_end_pos)
            begin
                res_valid         = 1'b1;
                res.control_field = ctrl_reg;
                if (rx_byte != END_CHAR)
                begin
                    res.status = ST_END_BAD;
                end
                else if (!addr_ok)
                begin
                    res.status = ST_ADDR_BAD;
                end
                else if (sum_bad_reg)
                begin
                    res.status = ST_SUM_BAD;
                end
                pos_next = 9'd0;
            end
            else
            begin
                if (pos_reg == fixed_end_pos - 9'd1)
                begin
                    sum_bad_next = (rx_byte != sum_reg);
                end
                else
                begin
                    if (pos_reg == 9'd1)
                    begin
                        ctrl_next = rx_byte;
                    end
                    else if (pos_reg == 9'd2)
                    begin
                        addr_lo_next = rx_byte;
                    end
                    else
                    begin
                        addr_hi_next = rx_byte;
                    end
                    sum_next = sum_reg + rx_byte;
                end
                pos_next = pos_inc;
            end
        end
        else
        begin
            pos_next = pos_inc;
            if (pos_reg == 9'd1)
            begin
                len_next = rx_byte;
            end
            else if (pos_reg == 9'd2)
            begin
                if (rx_byte != len_reg)
                begin
                    res_valid       = 1'b1;
                    res.status      = ST_LEN_BAD;
                    res.is_variable = 1'b1;
                    res.user_length = len_reg;
                    pos_next        = 9'd0;
                end
            end
            else if (pos_reg == 9'd3)
            begin
                if (rx_byte != VAR_START)
                begin
                    res_valid       = 1'b1;
                    res.status      = ST_START2_BAD;
                    res.is_variable = 1'b1;
                    res.user_length = len_reg;
                    pos_next        = 9'd0;
                end
            end
            else if (pos_reg <= data_last_pos)
            begin
                if (pos_reg == 9'd4)
                begin
                    ctrl_next = rx_byte;
                end
                else if (pos_reg == 9'd5)
                begin
                    addr_lo_next = rx_byte;
                end
                else if (pos_reg == 9'd6)
                begin
                    addr_hi_next = rx_byte;
                end
                sum_next = sum_reg + rx_byte;
            end
            else if (pos_reg == data_last_pos + 9'd1)
            begin
                sum_bad_next = (rx_byte != sum_reg);
            end
            else
            begin
                res_valid         = 1'b1;
                res.is_variable   = 1'b1;
                res.control_field = ctrl_reg;
                res.user_length   = len_reg;
                if (rx_byte != END_CHAR)
                begin
                    res.status = ST_END_BAD;
                end
                else if (sum_bad_reg)
                begin
                    res.status = ST_SUM_BAD;
                end
                else if (!addr_ok)
                begin
                    res.status = ST_ADDR_BAD;
                end
                pos_next = 9'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 9'd0;
            var_reg     <= 1'b0;
            len_reg     <= 8'h00;
            sum_reg     <= 8'h00;
            addr_lo_reg <= 8'h00;
            addr_hi_reg <= 8'h00;
            ctrl_reg    <= 8'h00;
            sum_bad_reg <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg     <= pos_next;
            var_reg     <= var_next;
            len_reg     <= len_next;
            sum_reg     <= sum_next;
            addr_lo_reg <= addr_lo_next;
            addr_hi_reg <= addr_hi_next;
            ctrl_reg    <= ctrl_next;
            sum_bad_reg <= sum_bad_next;
        end
    end
endmodule

[hdl/ft12_out_reg.sv]
module ft12_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              res_valid,
    input  ft12_pkg::result_t res,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    output logic              m_tuser
);
    import ft12_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    logic    load;
    result_t res_reg;

    assign load = advance && res_valid;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'b00000, res_reg.user_length, res_reg.control_field, res_reg.status};
    assign m_tuser  = res_reg.is_variable;
endmodule

[hdl/ft12_port_checker.sv]
`include "assert_macros.svh"

module ft12_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);
    import ft12_pkg::*;

    `ASSERT_IMPLIES(a_status_range, m_tvalid, m_tdata[2:0] <= ST_SUM_BAD, "status code out of range")

    `ASSERT_IMPLIES(a_pad_zero, m_tvalid, m_tdata[23:19] == 5'd0, "tdata padding not zero")

    // A byte that opens no frame reports nothing else.
    `ASSERT_IMPLIES(a_not_start_empty, m_tvalid && m_tdata[2:0] == ST_NOT_START,
        !m_tuser && m_tdata[18:3] == 16'd0, "not-start word carries frame fields")

    // Length and second-start errors come from variable frames before the control byte.
    `ASSERT_IMPLIES(a_early_error,
        m_tvalid && (m_tdata[2:0] == ST_LEN_BAD || m_tdata[2:0] == ST_START2_BAD),
        m_tuser && m_tdata[10:3] == 8'd0, "early error word malformed")

    `ASSERT_NEXT(a_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result word changed")
endmodule

bind ft12_frame_checker_core ft12_port_checker u_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
